@@ hdl/bfs_pkg.sv @@
package bfs_pkg;

  // Window geometry
  localparam int unsigned KERNEL = 7;
  localparam int unsigned HALF   = KERNEL / 2;
  localparam int unsigned AREA   = KERNEL * KERNEL;
  localparam int unsigned LINES  = KERNEL - 1;

  // Rounded divide by AREA: q = ((s + AREA/2) * RECIP_M) >> RECIP_SH, exact below 2^15
  localparam int unsigned ROUND    = AREA / 2;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_M  = ((1 << RECIP_SH) + AREA - 1) / AREA;

  // Field and state widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned VS_W    = 11;  // vertical sum of KERNEL pixels
  localparam int unsigned WS_W    = 14;  // window sum
  localparam int unsigned NUM_W   = WS_W + 1;
  localparam int unsigned LINE_W  = LINES * PIX_W;

  localparam int unsigned MAX_HEIGHT = 4095;
  localparam int unsigned RST_WIDTH  = 512;
  localparam int unsigned RST_HEIGHT = 512;

  // Output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             padding;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

endpackage

@@ hdl/bfs_if.sv @@
// Pixel request channel
interface bfs_pix_if import bfs_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Filtered pixel channel
interface bfs_res_if import bfs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bfs_line_mem.sv @@
module bfs_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, same-address write is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ hdl/bfs_out_fifo.sv @@
module bfs_out_fifo import bfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  res_t             push_data_i,
  output logic [OQ_CW-1:0] count_o,
  bfs_res_if.source        out_if
);

  res_t             buf_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CW-1:0] cnt_q;
  logic             pop;

  assign pop = out_if.valid && out_if.ready;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + OQ_CW'(1);
        2'b01:   cnt_q <= cnt_q - OQ_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_if.valid = (cnt_q != '0);
  assign out_if.data  = buf_q[rd_ptr_q];
  assign count_o      = cnt_q;

endmodule

@@ hdl/box_filter_7x7_stream_unit.sv @@
// 7x7 box mean filter on a raster stream of 8-bit pixels. One request (a pixel or, after
// the frame, a padding request) is taken per clock; each column's six earlier rows sit in
// one 48-bit word of a single line memory that is read when the pixel is taken and written
// back in the next cycle, so the pixel rate is one per clock while ready is high, set by
// that memory's one read and one write per cycle. A result passes through the memory read,
// the column and window sums and the reciprocal multiply into a four-entry output queue;
// input ready drops only when that queue and the two stages ahead of it could not hold more.
// Results trail the pixels by three rows and three columns, so 3*width+3 padding requests
// must follow each frame; the border three pixels deep reads as zero. Writing width or
// height restarts the frame and must happen only while the block is idle.
module box_filter_7x7_stream_unit import bfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bfs_pix_if.sink          in_if,
  bfs_res_if.source        out_if
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned EW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WCW = (EW > WIDTH_W) ? EW : WIDTH_W;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [CW-1:0]    addr;
    logic [LINES-1:0] mask;
    logic             is_pix;
    logic             emit;
    logic             interior;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             restart;
  } s1_t;

  typedef struct packed {
    logic [WS_W-1:0]  ws;
    logic             interior;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } s2_t;

  // Configuration
  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [WCW-1:0]     w_ext;
  logic [EW-1:0]      w_eff;
  logic [ROW_W-1:0]   h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(RST_WIDTH);
      height_q <= ROW_W'(RST_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[ROW_W-1:0];
        default:    width_q  <= width_q;
      endcase
    end
  end

  // Clamp to the supported frame size
  always_comb begin
    w_ext = WCW'(width_q);
    if (w_ext < WCW'(KERNEL)) begin
      w_eff = EW'(KERNEL);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_q);
    end
    if (height_q < ROW_W'(KERNEL)) begin
      h_eff = ROW_W'(KERNEL);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------- Stage 0: accept, position counters ----------------
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [CW-1:0]    in_col_q, out_col_q;
  logic [OQ_CW-1:0] oq_cnt;
  logic             v1_q, v2_q;
  logic             acc, in_frame, pix_go, pad_go, launch, emit0, emit_pix;
  logic             in_eol, out_eol, out_last, out_interior;
  logic [LINES-1:0] row_mask;
  s1_t              s1_q, s1_d;

  // Credit against the output queue and the two stages ahead of it
  assign in_if.ready = (oq_cnt + OQ_CW'(v1_q) + OQ_CW'(v2_q)) < OQ_CW'(OQ_DEPTH);

  assign acc      = in_if.valid && in_if.ready;
  assign in_frame = in_row_q < h_eff;
  assign pix_go   = acc && in_frame && !in_if.data.padding;
  assign pad_go   = acc && !in_frame && in_if.data.padding;
  assign emit_pix = (in_row_q > ROW_W'(HALF)) ||
                    ((in_row_q == ROW_W'(HALF)) && (in_col_q >= CW'(HALF)));
  assign emit0    = (pix_go && emit_pix) || pad_go;
  assign launch   = pix_go || pad_go;

  assign in_eol   = (EW'(in_col_q) + EW'(1)) == w_eff;
  assign out_eol  = (EW'(out_col_q) + EW'(1)) == w_eff;
  assign out_last = (out_row_q == (h_eff - ROW_W'(1))) && out_eol;
  assign out_interior = (out_row_q >= ROW_W'(HALF)) &&
                        (out_row_q < (h_eff - ROW_W'(HALF))) &&
                        (out_col_q >= CW'(HALF)) &&
                        (EW'(out_col_q) < (w_eff - EW'(HALF)));

  // Line j holds the row j+1 above; rows above the frame read as zero
  always_comb begin
    for (int j = 0; j < LINES; j++) begin
      row_mask[j] = in_row_q > ROW_W'(j);
    end
  end

  always_comb begin
    s1_d.px       = in_if.data.pixel;
    s1_d.addr     = in_col_q;
    s1_d.mask     = row_mask;
    s1_d.is_pix   = pix_go;
    s1_d.emit     = emit0;
    s1_d.interior = out_interior;
    s1_d.row      = out_row_q;
    s1_d.col      = COL_W'(out_col_q);
    s1_d.last     = out_last;
    s1_d.restart  = emit0 && out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_we_i) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (launch) begin
      if (pix_go) begin
        if (in_eol) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (emit0) begin
        if (out_last) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end else if (out_eol) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      s1_q <= s1_d;
    end
  end

  // ---------------- Line memory ----------------
  logic [LINE_W-1:0] rd_word, wr_word;
  logic              wr_en;

  bfs_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (LINE_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (pix_go),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (wr_word)
  );

  // ---------------- Stage 1: column and window sums ----------------
  logic [VS_W-1:0] cs_q [KERNEL];
  logic [WS_W-1:0] ws_q, ws_new;
  logic [VS_W-1:0] vs;
  s2_t             s2_q, s2_d;

  assign wr_en   = v1_q && s1_q.is_pix;
  assign wr_word = {rd_word[LINE_W-PIX_W-1:0], s1_q.px};

  always_comb begin
    vs = VS_W'(s1_q.px);
    for (int j = 0; j < LINES; j++) begin
      if (s1_q.mask[j]) begin
        vs = vs + VS_W'(rd_word[j*PIX_W +: PIX_W]);
      end
    end
  end

  assign ws_new = ws_q + WS_W'(vs) - WS_W'(cs_q[KERNEL-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      for (int j = 0; j < KERNEL; j++) begin
        cs_q[j] <= '0;
      end
    end else if (cfg_we_i || (v1_q && s1_q.restart)) begin
      ws_q <= '0;
      for (int j = 0; j < KERNEL; j++) begin
        cs_q[j] <= '0;
      end
    end else if (wr_en) begin
      ws_q    <= ws_new;
      cs_q[0] <= vs;
      for (int j = 1; j < KERNEL; j++) begin
        cs_q[j] <= cs_q[j-1];
      end
    end
  end

  always_comb begin
    s2_d.ws       = s1_q.is_pix ? ws_new : ws_q;
    s2_d.interior = s1_q.interior;
    s2_d.row      = s1_q.row;
    s2_d.col      = s1_q.col;
    s2_d.last     = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= launch;
      v2_q <= v1_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && s1_q.emit) begin
      s2_q <= s2_d;
    end
  end

  // ---------------- Stage 2: rounded mean by reciprocal ----------------
  logic [NUM_W-1:0]   num;
  logic [2*NUM_W-1:0] prod;
  res_t               res;

  assign num  = NUM_W'(s2_q.ws) + NUM_W'(ROUND);
  assign prod = (2*NUM_W)'(num) * (2*NUM_W)'(RECIP_M);

  always_comb begin
    res.value = s2_q.interior ? prod[RECIP_SH +: PIX_W] : '0;
    res.row   = s2_q.row;
    res.col   = s2_q.col;
    res.last  = s2_q.last;
  end

  bfs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (v2_q),
    .push_data_i (res),
    .count_o     (oq_cnt),
    .out_if      (out_if)
  );

  // ---------------- Checks ----------------
  // Credit scheme keeps the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !(out_if.valid && out_if.ready) |-> oq_cnt < OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  // Input column stays inside the active width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(in_col_q) < w_eff)
    else $error("input column beyond width");

  // Interior mean never exceeds a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && s2_q.interior |-> prod[2*NUM_W-1:RECIP_SH+PIX_W] == '0)
    else $error("mean out of range");

  // Frame end happens only on a flush request, never on a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && s1_q.restart |-> !s1_q.is_pix)
    else $error("frame restart on a pixel");

endmodule
